// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// Needs a clock named clk and an active-low reset named arst_n where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define FIR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define FIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fir_pkg.sv -----
// Shared types and constants for the direct-form FIR filter.
// No dependencies; imported by the filter top level and its checker.
package fir_pkg;

	// Storage sizes and data widths.
	localparam int MAX_TAPS   = 64;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int TAP_AW     = $clog2(MAX_TAPS);
	localparam int CNT_W      = TAP_AW + 1;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + TAP_AW;
	localparam int RND_W      = ACC_W + 1;

	// Configuration register widths and reset values.
	localparam int TAP_CNT_W  = 7;
	localparam int SHIFT_W    = 5;
	localparam int CFG_DATA_W = 7;
	localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = TAP_CNT_W'(1);
	localparam logic [SHIFT_W-1:0]   SHIFT_RST   = SHIFT_W'(15);

	// Stream payload layout.
	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;

	// Register indexes on the configuration port.
	typedef enum logic {
		CFG_TAP_COUNT    = 1'b0,
		CFG_OUTPUT_SHIFT = 1'b1
	} cfg_index_t;

	// Item kinds carried in the input tuser.
	typedef enum logic {
		OP_LOAD_COEF = 1'b0,
		OP_PUSH      = 1'b1
	} fir_op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_ROUND,
		ST_SHIFT
	} fir_state_t;

	// Controls from the sequencer to the datapath.
	typedef struct packed {
		logic in_ready;
		logic issue;
		logic round_en;
		logic out_load;
	} fir_ctrl_t;

endpackage

// ----- hw/rtl/fir_filter_convolution.sv -----
// Direct-form FIR filter with one shared multiply-accumulate unit.
// Depends on fir_pkg for widths, codes and sequencer types.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------------
//  s_axis    | in        | tvalid / tready       | tdata: coef_index, data_value
//            |           |                       | tuser: opcode, first_sample
//  m_axis    | out       | tvalid / tready       | tdata: filtered_sample
//            |           |                       | tuser: saturated
//  cfg       | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A load request leaves the input ready for the next request. A push request keeps the
// input busy while the sequencer reads a coefficient and a history entry for each of
// min(tap_count, 64) taps, one tap per cycle (none with a tap count of zero), drains the
// multiplier and accumulator, then passes a rounding state and a shift-and-clip state.
// The shift-and-clip state stalls while the output register still holds an earlier
// result that the downstream side has not taken. Reset clears the history at once through
// per-entry valid bits; coefficients are undefined until loaded. A finished result waits
// in the output register while the next request is taken.
module fir_filter_convolution
	import fir_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [5:0] coef_index, [21:6] data_value
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [0] opcode, [1] first_sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] filtered_sample
	output logic                   m_axis_tuser,  // [0] saturated
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Input field decode.
	logic [TAP_AW-1:0]          in_coef_index;
	logic signed [SAMPLE_W-1:0] in_data_value;
	logic                       in_opcode;
	logic                       in_first;
	logic                       in_accept;
	logic                       push_accept;
	logic                       load_accept;

	// Configuration registers.
	logic [TAP_CNT_W-1:0] tap_count_q;
	logic [SHIFT_W-1:0]   output_shift_q;

	// Sequencer.
	fir_state_t state_q;
	fir_state_t state_d;
	fir_ctrl_t  ctrl;
	logic       mac_done;

	// Storage.
	logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
	logic [MAX_TAPS-1:0]        hist_vld_q;
	logic [TAP_AW-1:0]          wr_ptr_q;
	logic [TAP_AW-1:0]          wr_ptr_new;

	// Multiply-accumulate datapath.
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           taps_eff;
	logic [TAP_AW-1:0]          hist_addr;
	logic signed [COEF_W-1:0]   coef_s1;
	logic signed [SAMPLE_W-1:0] hist_s1;
	logic                       hist_ok_s1;
	logic                       vld_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       vld_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// Rounding, shift and clip.
	logic signed [RND_W-1:0]    rnd_q;
	logic [RND_W-1:0]           rnd_const;
	logic signed [RND_W-1:0]    shifted;
	logic [RND_W-SAMPLE_W:0]    top_bits;
	logic                       fits;
	logic [SAMPLE_W-1:0]        clip_value;
	logic                       out_vld_q;
	logic [SAMPLE_W-1:0]        out_data_q;
	logic                       out_sat_q;

	assign in_coef_index = s_axis_tdata[TAP_AW-1:0];
	assign in_data_value = s_axis_tdata[TAP_AW +: SAMPLE_W];
	assign in_opcode     = s_axis_tuser[0];
	assign in_first      = s_axis_tuser[1];
	assign in_accept     = s_axis_tvalid && ctrl.in_ready;
	assign push_accept   = in_accept && (in_opcode == OP_PUSH);
	assign load_accept   = in_accept && (in_opcode == OP_LOAD_COEF);

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q    <= TAP_CNT_RST;
			output_shift_q <= SHIFT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TAP_COUNT:    tap_count_q    <= cfg_data[TAP_CNT_W-1:0];
				CFG_OUTPUT_SHIFT: output_shift_q <= cfg_data[SHIFT_W-1:0];
				default:          ;
			endcase
		end
	end

	// Active taps, limited to the size of the stores.
	always_comb begin
		if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps_eff = CNT_W'(MAX_TAPS);
		end else begin
			taps_eff = CNT_W'(tap_count_q);
		end
	end

	// The walk is finished once every tap was issued and the pipeline has drained.
	assign mac_done = (cnt_q == taps_eff) && !vld_s1 && !vld_s2;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (push_accept) state_d = ST_MAC;
			ST_MAC:   if (mac_done) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_SHIFT;
			ST_SHIFT: if (ctrl.out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:  ctrl.in_ready = 1'b1;
			ST_MAC:   ctrl.issue    = (cnt_q < taps_eff);
			ST_ROUND: ctrl.round_en = 1'b1;
			ST_SHIFT: ctrl.out_load = !out_vld_q || m_axis_tready;
			default:  ;
		endcase
	end

	assign s_axis_tready = ctrl.in_ready;

	// Coefficient store: written by load requests, read one tap per cycle.
	always_ff @(posedge clk) begin
		if (load_accept) begin
			coef_mem[in_coef_index] <= in_data_value;
		end
		if (ctrl.issue) begin
			coef_s1 <= coef_mem[cnt_q[TAP_AW-1:0]];
		end
	end

	// History as a circular buffer; the newest sample sits at the write pointer.
	// The address wraps naturally since the depth is a power of two.
	assign wr_ptr_new = wr_ptr_q - TAP_AW'(1);
	assign hist_addr  = wr_ptr_q + cnt_q[TAP_AW-1:0];

	always_ff @(posedge clk) begin
		if (push_accept) begin
			hist_mem[wr_ptr_new] <= in_data_value;
		end
		if (ctrl.issue) begin
			hist_s1 <= hist_mem[hist_addr];
		end
	end

	// Valid bits make unwritten or cleared history entries read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			wr_ptr_q   <= '0;
			hist_ok_s1 <= 1'b0;
		end else begin
			if (push_accept) begin
				wr_ptr_q <= wr_ptr_new;
				if (in_first) begin
					hist_vld_q <= MAX_TAPS'(1) << wr_ptr_new;
				end else begin
					hist_vld_q[wr_ptr_new] <= 1'b1;
				end
			end
			if (ctrl.issue) begin
				hist_ok_s1 <= hist_vld_q[hist_addr];
			end
		end
	end

	// Tap counter and pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (push_accept) begin
				cnt_q <= '0;
			end else if (ctrl.issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			vld_s1 <= ctrl.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Shared multiplier, registered before accumulation.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= coef_s1 * (hist_ok_s1 ? hist_s1 : SAMPLE_W'(0));
		end
	end

	// Accumulator, cleared when a push is taken.
	always_ff @(posedge clk) begin
		if (push_accept) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{TAP_AW{prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// Rounding: add half of the last kept unit, nothing for a zero shift.
	always_comb begin
		if (output_shift_q == '0) begin
			rnd_const = '0;
		end else begin
			rnd_const = RND_W'(1) << (output_shift_q - SHIFT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.round_en) begin
			rnd_q <= {acc_q[ACC_W-1], acc_q} + rnd_const;
		end
	end

	// Arithmetic shift and clip to the sample range.
	assign shifted  = rnd_q >>> output_shift_q;
	assign top_bits = shifted[RND_W-1:SAMPLE_W-1];
	assign fits     = (&top_bits) || !(|top_bits);

	always_comb begin
		if (fits) begin
			clip_value = shifted[SAMPLE_W-1:0];
		end else if (shifted[RND_W-1]) begin
			clip_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			clip_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// Output register: holds a result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_data_q <= clip_value;
			out_sat_q  <= !fits;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);
	assign m_axis_tuser  = out_sat_q;

endmodule

// ----- hw/rtl/fir_checker.sv -----
// Port-level checker for the FIR filter, bound to its top level below.
// Depends on fir_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module fir_checker
	import fir_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	localparam logic [OUT_TDATA_W-1:0] SAT_HI = {1'b0, {(OUT_TDATA_W-1){1'b1}}};
	localparam logic [OUT_TDATA_W-1:0] SAT_LO = {1'b1, {(OUT_TDATA_W-1){1'b0}}};

	logic push_req;
	logic load_req;

	assign push_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_PUSH);
	assign load_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD_COEF);

	// A result that is stalled keeps its value and flag.
	`FIR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// A coefficient load never produces a result.
	`FIR_ASSERT_NEXT(a_load_silent, load_req, !$rose(m_axis_tvalid), "result raised by a coefficient load")

	// The filter is busy once a push request was taken.
	`FIR_ASSERT_NEXT(a_push_busy, push_req, !s_axis_tready, "input ready straight after a push")

	// A clipped result sits at one end of the sample range.
	`FIR_ASSERT_IMPL(a_sat_range, m_axis_tvalid && m_axis_tuser, m_axis_tdata == SAT_HI || m_axis_tdata == SAT_LO, "saturated result not at a range limit")

endmodule

bind fir_filter_convolution fir_checker u_fir_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for the direct-form FIR filter top level.
// Depends on fir_pkg for widths, item kinds and register indexes, and on the filter RTL.
module testbench
	import fir_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Idle cycles waited after every expected result has arrived.
	localparam int SETTLE_CYCLES = MAX_TAPS + 16;
	localparam int CYCLE_LIMIT   = 600_000;
	localparam int PHASE_ITEMS   = 100;
	localparam int PHASE_COUNT   = 10;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                clipped;
	} fir_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	cfg_index_t             cfg_index = CFG_TAP_COUNT;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Filter state as predicted from the accepted requests.
	logic signed [COEF_W-1:0]   coef_bank [MAX_TAPS];
	bit                         coef_written [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
	logic [TAP_CNT_W-1:0]       taps_reg = TAP_CNT_RST;
	logic [SHIFT_W-1:0]         shift_reg = SHIFT_RST;

	fir_result_t expected_outputs [$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          gaps_on = 1'b1;
	int          ready_hold = 0;

	fir_filter_convolution u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Update the predicted state for one accepted request and queue the result of a push.
	task automatic apply_request(fir_op_t op, logic [TAP_AW-1:0] idx,
			logic [SAMPLE_W-1:0] val, bit first);
		longint      acc;
		longint      rounded;
		int          active;
		int          j;
		fir_result_t want;
		if (op == OP_LOAD_COEF) begin
			coef_bank[idx] = val;
			coef_written[idx] = 1'b1;
			return;
		end
		// A new signal starts from an empty history line.
		if (first) begin
			for (j = 0; j < MAX_TAPS; j++)
				history[j] = '0;
		end
		for (j = MAX_TAPS - 1; j > 0; j--)
			history[j] = history[j-1];
		history[0] = val;
		// Sum over the active taps; counts above the store size use every tap.
		active = (taps_reg > MAX_TAPS) ? MAX_TAPS : int'(taps_reg);
		acc = 0;
		for (j = 0; j < active; j++)
			acc += longint'(coef_bank[j]) * longint'(history[j]);
		// Round half up, then an arithmetic shift, then clip to the sample range.
		if (shift_reg != 0)
			acc += longint'(1) << (shift_reg - 1);
		rounded = acc >>> shift_reg;
		want.clipped = 1'b1;
		if (rounded > 32767)
			rounded = 32767;
		else if (rounded < -32768)
			rounded = -32768;
		else
			want.clipped = 1'b0;
		want.sample = SAMPLE_W'(rounded);
		expected_outputs.push_back(want);
	endtask

	// Offer one request on the input stream, sometimes after an idle burst.
	task automatic send_request(fir_op_t op, logic [TAP_AW-1:0] idx,
			logic [SAMPLE_W-1:0] val, bit first);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, val, idx};
		s_axis_tuser  <= {first, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		apply_request(op, idx, val, first);
	endtask

	// Stop sending, let every expected result arrive and give the filter time to go idle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t which, logic [CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (which == CFG_TAP_COUNT)
			taps_reg = value;
		else
			shift_reg = value[SHIFT_W-1:0];
	endtask

	// Mostly random words, with the extremes and values near zero mixed in.
	function automatic logic [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 63)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	// Load every active coefficient slot that has never been written.
	task automatic load_missing_coefs();
		int slot;
		for (slot = 0; slot < MAX_TAPS && slot < taps_reg; slot++) begin
			if (!coef_written[slot])
				send_request(OP_LOAD_COEF, TAP_AW'(slot), pick_value(), 1'b0);
		end
	endtask

	task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
			logic [SAMPLE_W-1:0] want);
		if (error_count < 50)
			$display("mismatch %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	task automatic check_result();
		fir_result_t want;
		if (expected_outputs.size() == 0) begin
			report_mismatch("result with no request", m_axis_tdata, '0);
			return;
		end
		want = expected_outputs.pop_front();
		if (m_axis_tdata !== want.sample)
			report_mismatch("filtered_sample", m_axis_tdata, want.sample);
		if (m_axis_tuser !== want.clipped)
			report_mismatch("saturated", SAMPLE_W'(m_axis_tuser), SAMPLE_W'(want.clipped));
	endtask

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
	end

	// Receiver back-pressure in random bursts.
	always @(posedge clk) begin
		if (ready_hold > 1) begin
			ready_hold <= ready_hold - 1;
		end else if (ready_hold == 1) begin
			ready_hold <= 0;
			m_axis_tready <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			ready_hold <= $urandom_range(1, 13);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL fir_filter_convolution");
			$finish;
		end
	end

	// Default tap count and shift straight after reset, with full-scale values.
	task automatic test_reset_config();
		send_request(OP_LOAD_COEF, 6'd0, 16'h7FFF, 1'b0);
		send_request(OP_PUSH, 6'd0, 16'h7FFF, 1'b1);
		send_request(OP_PUSH, 6'd0, 16'h8000, 1'b0);
		send_request(OP_LOAD_COEF, 6'd0, 16'h8000, 1'b0);
		send_request(OP_PUSH, 6'd0, 16'h8000, 1'b0);
		send_request(OP_PUSH, 6'd0, 16'h7FFF, 1'b0);
	endtask

	// Clipping at both ends with no shift, then rounding of halves and negatives.
	task automatic test_rounding_and_clipping();
		write_register(CFG_OUTPUT_SHIFT, 7'd0);
		send_request(OP_PUSH, 6'd0, 16'h0001, 1'b1);
		send_request(OP_PUSH, 6'd0, 16'h0002, 1'b0);
		send_request(OP_PUSH, 6'd0, 16'h8000, 1'b0);
		write_register(CFG_OUTPUT_SHIFT, 7'd1);
		send_request(OP_LOAD_COEF, 6'd0, 16'h0001, 1'b0);
		send_request(OP_PUSH, 6'd0, 16'hFFFF, 1'b1);
		send_request(OP_PUSH, 6'd0, 16'hFFFD, 1'b1);
		send_request(OP_PUSH, 6'd0, 16'h0003, 1'b1);
	endtask

	// An empty sum, the top slot, an oversized tap count and the largest shift.
	task automatic test_tap_count_limits();
		write_register(CFG_TAP_COUNT, 7'd0);
		send_request(OP_PUSH, 6'd0, 16'h1234, 1'b1);
		send_request(OP_LOAD_COEF, 6'd63, 16'h7FFF, 1'b1);
		write_register(CFG_TAP_COUNT, 7'd127);
		write_register(CFG_OUTPUT_SHIFT, 7'd31);
		load_missing_coefs();
		send_request(OP_PUSH, 6'd0, 16'h7FFF, 1'b1);
		send_request(OP_PUSH, 6'd0, 16'h8000, 1'b0);
	endtask

	// Phases of random traffic, each under its own tap count and shift.
	task automatic test_random_traffic();
		int          phase;
		int          n;
		logic [6:0]  taps;
		logic [4:0]  shift;
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin taps = 7'd64;  shift = 5'd31; end
				1: begin taps = 7'd1;   shift = 5'd0;  end
				2: begin taps = 7'd127; shift = 5'd15; end
				3: begin taps = 7'd2;   shift = 5'd0;  end
				4: begin taps = 7'd65;  shift = 5'd14; end
				5: begin taps = 7'd0;   shift = 5'($urandom); end
				default: begin
					taps  = 7'($urandom_range(1, 127));
					shift = 5'($urandom_range(0, 31));
				end
			endcase
			// The closing phase runs with both sides at full rate.
			if (phase == PHASE_COUNT - 1)
				gaps_on = 1'b0;
			write_register(CFG_TAP_COUNT, taps);
			write_register(CFG_OUTPUT_SHIFT, {2'b00, shift});
			load_missing_coefs();
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0)
					send_request(OP_LOAD_COEF, 6'($urandom), pick_value(),
						1'($urandom));
				else
					send_request(OP_PUSH, 6'($urandom), pick_value(),
						$urandom_range(0, 24) == 0);
			end
		end
	endtask

	initial begin
		int j;
		for (j = 0; j < MAX_TAPS; j++) begin
			coef_bank[j] = '0;
			coef_written[j] = 1'b0;
			history[j] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_rounding_and_clipping();
		test_tap_count_limits();
		test_random_traffic();
		wait_idle();
		if (error_count == 0)
			$display("PASS fir_filter_convolution");
		else
			$display("FAIL fir_filter_convolution");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fir_pkg.sv
hw/rtl/fir_filter_convolution.sv
hw/rtl/fir_checker.sv
dv/testbench.sv
